/* rtl/bcb_pkg.sv */
// Package with the shared types, constants and codes of the betweenness engine.
`default_nettype none
package bcb_pkg;
    localparam int MaxNodes  = 64;
    localparam int MaxEdges  = 512;
    localparam int FracBits  = 16;
    localparam int NodeW     = 6;
    localparam int EdgeAddrW = 9;
    localparam int EdgeCntW  = 10;
    localparam int SigmaW    = 40;
    localparam int DepW      = 32;
    localparam int CentW     = 33;
    localparam int DistW     = 7;
    localparam int CountW    = 7;
    localparam int MdSteps   = 34;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_RUN    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [NodeW-1:0] node_a;
        logic [NodeW-1:0] node_b;
    } in_item_t;

    typedef struct packed {
        logic [NodeW-1:0] node_index;
        logic [31:0]      centrality;
        logic             last_node;
    } out_item_t;

    // Request to the shared multiply-divide unit.
    typedef struct packed {
        logic              start;
        logic [DepW+1:0]   a;
        logic [SigmaW-1:0] b;
        logic [SigmaW-1:0] d;
    } md_req_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [DepW+1:0] q;
    } md_rsp_t;
endpackage
`default_nettype wire

/* rtl/bcb_muldiv.sv */
// Bit-serial unit computing floor(a * min(b, d) / d) one bit of a per cycle.
`default_nettype none
module bcb_muldiv (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bcb_pkg::md_req_t req,
    output bcb_pkg::md_rsp_t      rsp
);
    import bcb_pkg::*;

    logic [DepW+1:0]   a_reg, a_next;
    logic [SigmaW-1:0] b_reg, b_next;
    logic [SigmaW-1:0] d_reg, d_next;
    logic [SigmaW:0]   r_reg, r_next;
    logic [DepW+1:0]   q_reg, q_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SigmaW+1:0] r1, r2;
    logic              q1, q2;

    always_comb
    begin
        a_next = a_reg; b_next = b_reg; d_next = d_reg; r_next = r_reg;
        q_next = q_reg; cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        r1 = '0; r2 = '0; q1 = 1'b0; q2 = 1'b0;
        if (req.start)
        begin
            a_next = req.a;
            d_next = req.d;
            b_next = (req.b > req.d) ? req.d : req.b;
            r_next = '0;
            q_next = '0;
            cnt_next = 6'(MdSteps);
            busy_next = (req.d != '0);
            done_next = (req.d == '0);
        end
        else if (busy_reg)
        begin
            r1 = {r_reg, 1'b0};
            if (r1 >= {2'b00, d_reg})
            begin
                r1 = r1 - {2'b00, d_reg};
                q1 = 1'b1;
            end
            r2 = r1;
            if (a_reg[DepW+1])
            begin
                r2 = r1 + {2'b00, b_reg};
                if (r2 >= {2'b00, d_reg})
                begin
                    r2 = r2 - {2'b00, d_reg};
                    q2 = 1'b1;
                end
            end
            r_next = r2[SigmaW:0];
            q_next = {q_reg[DepW:0], 1'b0} + (DepW+2)'(q1) + (DepW+2)'(q2);
            a_next = {a_reg[DepW:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next; b_reg <= b_next; d_reg <= d_next;
        r_reg <= r_next; q_reg <= q_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

`ifndef NO_ASSERTIONS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start) else $error("divider restarted while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done held longer than one cycle");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");
`endif
endmodule
`default_nettype wire

/* rtl/betweenness_centrality_brandes_top.sv */
// Top level of the exact Brandes betweenness centrality engine.
//
// Edges arrive through start/busy transfers and go into a 512-entry edge store;
// an add or clear transfer leaves busy low, so such items may be issued every
// cycle. A run transfer holds busy high while, for every source, a
// breadth-first search rescans the whole edge store once per visited node and a
// reverse pass rescans it once per visited node again. Each edge is fetched
// from the store and then its two sides are handled in turn; a side that
// touches the current node also reads that neighbor's node entries. Each
// predecessor term found in the reverse pass is computed in the shared
// bit-serial multiply-divide unit. Results cannot be stalled: each transfer
// of result_valid lasts one cycle, one per node, the last flagged.
// Configuration writes of node_count must happen while busy is low.
`default_nettype none
module betweenness_centrality_brandes_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire bcb_pkg::in_item_t  in_item,
    output logic                    result_valid,
    output bcb_pkg::out_item_t      result,
    input  wire logic               cfg_we,
    input  wire logic [6:0]         cfg_data
);
    import bcb_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_CLR     = 11'b00000000010,
        S_SRC     = 11'b00000000100,
        S_FPOP    = 11'b00000001000,
        S_FSCAN   = 11'b00000010000,
        S_FEDGE   = 11'b00000100000,
        S_BPOP    = 11'b00001000000,
        S_BSCAN   = 11'b00010000000,
        S_BEDGE   = 11'b00100000000,
        S_BWAIT   = 11'b01000000000,
        S_OUT     = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // Storage. Per-node arrays are read at signal-chosen places, so they are
    // kept as memories and visited one entry at a time by the sequencer.
    logic [2*NodeW-1:0] edge_mem [MaxEdges];
    logic [DistW-1:0]   dist_mem [MaxNodes];
    logic [SigmaW-1:0]  sig_mem  [MaxNodes];
    logic [DepW-1:0]    dep_mem  [MaxNodes];
    logic [CentW-1:0]   cent_mem [MaxNodes];
    logic [NodeW-1:0]   order_mem[MaxNodes];
    logic [MaxNodes-1:0] reached_reg, reached_next;

    logic [EdgeCntW-1:0] etotal_reg, etotal_next;
    logic [CountW-1:0]   ncfg_reg;
    logic [CountW-1:0]   n_reg, n_next;
    logic [CountW-1:0]   src_reg, src_next;
    logic [CountW-1:0]   head_reg, head_next;
    logic [CountW-1:0]   tail_reg, tail_next;
    logic [NodeW-1:0]    cur_reg, cur_next;
    logic [DistW-1:0]    cdist_reg, cdist_next;
    logic [SigmaW-1:0]   csig_reg, csig_next;
    logic [DepW-1:0]     cdep_reg, cdep_next;
    logic [EdgeCntW-1:0] eidx_reg, eidx_next;
    logic                side_reg, side_next;
    logic [2*NodeW-1:0]  edge_q;
    logic [NodeW-1:0]    nb_reg, nb_next;
    logic [CountW-1:0]   clr_reg, clr_next;
    logic [1:0]          ph_reg, ph_next;

    // Registered read data of the node memories.
    logic [DistW-1:0]  dist_q;
    logic [SigmaW-1:0] sig_q;
    logic [DepW-1:0]   dep_q;
    logic [CentW-1:0]  cent_q;
    logic [NodeW-1:0]  order_q;
    logic [NodeW-1:0]  raddr;
    logic [CountW-1:0] oaddr;

    // Write ports.
    logic              dist_we, sig_we, dep_we, cent_we, order_we, edge_we;
    logic [NodeW-1:0]  waddr, oaddr_w;
    logic [DistW-1:0]  dist_wd;
    logic [SigmaW-1:0] sig_wd;
    logic [DepW-1:0]   dep_wd;
    logic [CentW-1:0]  cent_wd;
    logic [NodeW-1:0]  order_wd;

    md_req_t md_req;
    md_rsp_t md_rsp;

    logic              res_v_reg, res_v_next;
    out_item_t         res_reg, res_next;

    logic [NodeW-1:0]  ea, eb;
    logic              e_ok;
    logic [SigmaW:0]   sig_sum;
    logic [DepW:0]     dep_sum;
    logic [CentW:0]    cent_sum;

    bcb_muldiv u_md (
        .clk (clk),
        .rst_n (rst_n),
        .req (md_req),
        .rsp (md_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[etotal_reg[EdgeAddrW-1:0]] <= {in_item.node_a, in_item.node_b};
        edge_q <= edge_mem[eidx_reg[EdgeAddrW-1:0]];
        if (dist_we)  dist_mem[waddr]  <= dist_wd;
        if (sig_we)   sig_mem[waddr]   <= sig_wd;
        if (dep_we)   dep_mem[waddr]   <= dep_wd;
        if (cent_we)  cent_mem[waddr]  <= cent_wd;
        if (order_we) order_mem[oaddr_w] <= order_wd;
        dist_q  <= dist_mem[raddr];
        sig_q   <= sig_mem[raddr];
        dep_q   <= dep_mem[raddr];
        cent_q  <= cent_mem[raddr];
        order_q <= order_mem[oaddr[NodeW-1:0]];
    end

    assign ea   = edge_q[2*NodeW-1:NodeW];
    assign eb   = edge_q[NodeW-1:0];
    assign e_ok = ({1'b0, ea} < n_reg) && ({1'b0, eb} < n_reg);

    // Read address: counter in clear/output, popped node in pops, else neighbor.
    always_comb
    begin
        raddr = nb_reg;
        if (state_reg == S_OUT || state_reg == S_CLR)
            raddr = clr_reg[NodeW-1:0];
        else if (state_reg == S_FPOP || state_reg == S_BPOP)
            raddr = order_q;
        oaddr = (state_reg == S_BPOP) ? tail_reg - 7'd1 : head_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        etotal_next = etotal_reg; n_next = n_reg; src_next = src_reg;
        head_next = head_reg; tail_next = tail_reg; cur_next = cur_reg;
        cdist_next = cdist_reg; csig_next = csig_reg; cdep_next = cdep_reg;
        eidx_next = eidx_reg; side_next = side_reg; nb_next = nb_reg;
        clr_next = clr_reg; ph_next = ph_reg; reached_next = reached_reg;
        res_v_next = 1'b0; res_next = res_reg;
        edge_we = 1'b0; dist_we = 1'b0; sig_we = 1'b0; dep_we = 1'b0;
        cent_we = 1'b0; order_we = 1'b0;
        waddr = nb_reg; oaddr_w = tail_reg[NodeW-1:0];
        dist_wd = '0; sig_wd = '0; dep_wd = '0; cent_wd = '0; order_wd = nb_reg;
        md_req = '0;
        sig_sum = '0; dep_sum = '0; cent_sum = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    priority if (in_item.op == OP_ADD)
                    begin
                        if (etotal_reg < EdgeCntW'(MaxEdges))
                        begin
                            edge_we = 1'b1;
                            etotal_next = etotal_reg + 1'b1;
                        end
                    end
                    else if (in_item.op == OP_CLEAR)
                        etotal_next = '0;
                    else if (in_item.op == OP_RUN)
                    begin
                        n_next = (ncfg_reg == '0) ? 7'd1
                               : (ncfg_reg > 7'(MaxNodes)) ? 7'(MaxNodes) : ncfg_reg;
                        clr_next = '0;
                        state_next = S_CLR;
                    end
                end
            end
            // Clear the centrality sums of the nodes in use.
            S_CLR:
            begin
                cent_we = 1'b1;
                waddr = clr_reg[NodeW-1:0];
                cent_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg + 1'b1 == n_reg)
                begin
                    src_next = '0;
                    clr_next = '0;
                    state_next = S_SRC;
                end
            end
            // Source setup: clear delta; sigma is 1 at the source, 0 elsewhere.
            S_SRC:
            begin
                waddr = clr_reg[NodeW-1:0];
                sig_we = 1'b1; dep_we = 1'b1;
                sig_wd = (clr_reg == src_reg) ? SigmaW'(1) : '0;
                dep_wd = '0;
                if (clr_reg == src_reg)
                begin
                    dist_we = 1'b1;
                    dist_wd = '0;
                    order_we = 1'b1;
                    oaddr_w = '0;
                    order_wd = src_reg[NodeW-1:0];
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg + 1'b1 == n_reg)
                begin
                    reached_next = '0;
                    reached_next[src_reg[NodeW-1:0]] = 1'b1;
                    head_next = '0;
                    tail_next = 7'd1;
                    ph_next = '0;
                    state_next = S_FPOP;
                end
            end
            // Pop the next node of the search queue (two-step memory read).
            S_FPOP:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd0)
                begin
                    if (head_reg == tail_reg)
                    begin
                        ph_next = '0;
                        state_next = S_BPOP;
                    end
                end
                else if (ph_reg == 2'd2)
                begin
                    cur_next = order_q;
                    cdist_next = dist_q;
                    csig_next = sig_q;
                    head_next = head_reg + 1'b1;
                    eidx_next = '0;
                    ph_next = '0;
                    state_next = S_FSCAN;
                end
            end
            S_FSCAN:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd0)
                begin
                    if (eidx_reg == etotal_reg)
                    begin
                        state_next = S_FPOP;
                        ph_next = '0;
                    end
                end
                else
                begin
                    side_next = 1'b0;
                    ph_next = '0;
                    state_next = S_FEDGE;
                end
            end
            // Handle one side of an edge in the forward search.
            S_FEDGE:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd0)
                begin
                    if (e_ok && ((!side_reg && ea == cur_reg) ||
                                 (side_reg && eb == cur_reg)))
                        nb_next = side_reg ? ea : eb;
                    else
                        ph_next = 2'd3;
                end
                else if (ph_reg == 2'd2)
                begin
                    if (!reached_reg[nb_reg] && tail_reg < 7'(MaxNodes))
                    begin
                        reached_next[nb_reg] = 1'b1;
                        dist_we = 1'b1;
                        dist_wd = cdist_reg + 1'b1;
                        order_we = 1'b1;
                        tail_next = tail_reg + 1'b1;
                        sig_we = 1'b1;
                        sig_sum = {1'b0, sig_q} + {1'b0, csig_reg};
                        sig_wd = sig_sum[SigmaW] ? '1 : sig_sum[SigmaW-1:0];
                    end
                    else if (reached_reg[nb_reg] && dist_q == cdist_reg + 1'b1)
                    begin
                        sig_we = 1'b1;
                        sig_sum = {1'b0, sig_q} + {1'b0, csig_reg};
                        sig_wd = sig_sum[SigmaW] ? '1 : sig_sum[SigmaW-1:0];
                    end
                end
                if (ph_next == 2'd3)
                begin
                    ph_next = '0;
                    side_next = 1'b1;
                    if (side_reg)
                    begin
                        eidx_next = eidx_reg + 1'b1;
                        state_next = S_FSCAN;
                    end
                end
            end
            // Reverse pass: pop from the tail of the visit order.
            S_BPOP:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd0)
                begin
                    if (tail_reg == '0)
                    begin
                        ph_next = '0;
                        src_next = src_reg + 1'b1;
                        clr_next = '0;
                        state_next = (src_reg + 1'b1 == n_reg) ? S_OUT : S_SRC;
                    end
                end
                else if (ph_reg == 2'd2)
                begin
                    cur_next = order_q;
                    cdist_next = dist_q;
                    csig_next = sig_q;
                    cdep_next = dep_q;
                    tail_next = tail_reg - 1'b1;
                    eidx_next = '0;
                    ph_next = '0;
                    state_next = S_BSCAN;
                end
            end
            S_BSCAN:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd0)
                begin
                    if (eidx_reg == etotal_reg)
                    begin
                        ph_next = '0;
                        nb_next = cur_reg;
                        state_next = S_BWAIT;
                    end
                end
                else
                begin
                    side_next = 1'b0;
                    ph_next = '0;
                    state_next = S_BEDGE;
                end
            end
            S_BEDGE:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd0)
                begin
                    if (e_ok && ((!side_reg && ea == cur_reg) ||
                                 (side_reg && eb == cur_reg)))
                        nb_next = side_reg ? ea : eb;
                    else
                        ph_next = 2'd3;
                end
                else if (ph_reg == 2'd2)
                begin
                    if (reached_reg[nb_reg] && dist_q + 1'b1 == cdist_reg)
                    begin
                        md_req.start = 1'b1;
                        md_req.a = (DepW+2)'(cdep_reg) + (DepW+2)'(1 << FracBits);
                        md_req.b = sig_q;
                        md_req.d = csig_reg;
                        ph_next = 2'd3;
                        state_next = S_BWAIT;
                    end
                    else
                        ph_next = 2'd3;
                end
                if (ph_next == 2'd3 && state_next == S_BEDGE)
                begin
                    ph_next = '0;
                    side_next = 1'b1;
                    if (side_reg)
                    begin
                        eidx_next = eidx_reg + 1'b1;
                        state_next = S_BSCAN;
                    end
                end
            end
            // Wait for the divider and add the term, or finish the node.
            S_BWAIT:
            begin
                if (eidx_reg == etotal_reg)
                begin
                    // Node end: add delta to centrality (not for the source).
                    ph_next = ph_reg + 2'd1;
                    if (ph_reg == 2'd1)
                    begin
                        if (cur_reg != src_reg[NodeW-1:0])
                        begin
                            cent_we = 1'b1;
                            waddr = cur_reg;
                            cent_sum = {1'b0, cent_q} + (CentW+1)'(cdep_reg);
                            cent_wd = cent_sum[CentW] ? '1 : cent_sum[CentW-1:0];
                        end
                        ph_next = '0;
                        state_next = S_BPOP;
                    end
                end
                else if (md_rsp.done)
                begin
                    dep_we = 1'b1;
                    dep_sum = {1'b0, dep_q} + (DepW+1)'(md_rsp.q);
                    dep_wd = (dep_sum[DepW] || md_rsp.q[DepW+1:DepW] != '0)
                           ? '1 : dep_sum[DepW-1:0];
                    ph_next = '0;
                    side_next = 1'b1;
                    state_next = S_BEDGE;
                    if (side_reg)
                    begin
                        eidx_next = eidx_reg + 1'b1;
                        state_next = S_BSCAN;
                    end
                end
            end
            S_OUT:
            begin
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd1)
                begin
                    ph_next = '0;
                    res_v_next = 1'b1;
                    res_next.node_index = clr_reg[NodeW-1:0];
                    res_next.centrality = cent_q[CentW-1:1];
                    res_next.last_node = (clr_reg + 1'b1 == n_reg);
                    clr_next = clr_reg + 1'b1;
                    if (clr_reg + 1'b1 == n_reg)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            etotal_reg <= '0;
            ncfg_reg   <= 7'(MaxNodes);
            res_v_reg  <= 1'b0;
            ph_reg     <= '0;
            clr_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            etotal_reg <= etotal_next;
            if (cfg_we)
                ncfg_reg <= cfg_data;
            res_v_reg  <= res_v_next;
            ph_reg     <= ph_next;
            clr_reg    <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next; src_reg <= src_next; head_reg <= head_next;
        tail_reg <= tail_next; cur_reg <= cur_next; cdist_reg <= cdist_next;
        csig_reg <= csig_next; cdep_reg <= cdep_next; eidx_reg <= eidx_next;
        side_reg <= side_next; nb_reg <= nb_next; reached_reg <= reached_next;
        res_reg <= res_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_v_reg;
    assign result       = res_reg;

`ifndef NO_ASSERTIONS
    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_v_reg |-> ($past(state_reg) == S_OUT)) else $error("result outside output");
    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        etotal_reg <= EdgeCntW'(MaxEdges)) else $error("edge count overflow");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_v_reg && res_reg.last_node) |-> state_reg == S_IDLE)
        else $error("last result before the run ended");
`endif
endmodule
`default_nettype wire
